### rtl/pclut_pkg.sv
// ----------------------------------------------------------------------------
// pclut_pkg
// Shared constants, codes, types and the ARGB8888 expansion function of the
// palette color lookup table.
// ----------------------------------------------------------------------------
package pclut_pkg;

	localparam int MAX_PALETTES = 16;
	localparam int MAX_COLORS   = 256;
	localparam int PAL_W        = $clog2(MAX_PALETTES);
	localparam int COL_W        = $clog2(MAX_COLORS);
	localparam int ADDR_W       = PAL_W + COL_W;
	localparam int LP_W         = PAL_W + 1;

	// operations
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	// register indexes
	localparam int          REG_IDX_W      = 2;
	localparam logic [1:0]  REG_FORMAT     = 2'd0;
	localparam logic [1:0]  REG_PAL_COUNT  = 2'd1;
	localparam logic [1:0]  REG_COL_COUNT  = 2'd2;

	// source formats
	localparam logic [1:0] FMT_8888 = 2'd0;
	localparam logic [1:0] FMT_4444 = 2'd1;
	localparam logic [1:0] FMT_1555 = 2'd2;
	localparam logic [1:0] FMT_565  = 2'd3;

	localparam logic [15:0] KEY_565 = 16'hF81F;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [1:0]        fmt;
		logic [7:0]        pal_count;
		logic [7:0]        col_count;
	} pclut_ctrl_t;

	function automatic logic [31:0] expand(input logic [1:0] fmt, input logic [31:0] w);
		logic [15:0] c;
		logic [31:0] r;
		c = w[15:0];
		case (fmt)
			FMT_8888: r = w;
			FMT_4444: r = {c[15:12], c[15:12], c[11:8], c[11:8],
				c[7:4], c[7:4], c[3:0], c[3:0]};
			FMT_1555: r = c[15] ? {8'hFF, c[14:10], 3'b000, c[9:5], 3'b000,
				c[4:0], 3'b000} : 32'h0;
			FMT_565:  r = (c == KEY_565) ? 32'h0 : {8'hFF, c[15:11], 3'b000,
				c[10:5], 2'b00, c[4:0], 3'b000};
			default:  r = w;
		endcase
		return r;
	endfunction

endpackage

### rtl/pclut_req_if.sv
// ----------------------------------------------------------------------------
// pclut_req_if
// Request channel: load or read items with valid/ready.
// ----------------------------------------------------------------------------
interface pclut_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] raw_word;
	logic [7:0]  palette_index;
	logic [7:0]  entry_index;

	modport source (output valid, operation, raw_word, palette_index, entry_index,
		input ready);
	modport sink (input valid, operation, raw_word, palette_index, entry_index,
		output ready);
endinterface

### rtl/pclut_rsp_if.sv
// ----------------------------------------------------------------------------
// pclut_rsp_if
// Response channel: looked-up color and range flag with valid/ready.
// ----------------------------------------------------------------------------
interface pclut_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] color;
	logic        in_range;

	modport source (output valid, color, in_range, input ready);
	modport sink (input valid, color, in_range, output ready);
endinterface

### rtl/pclut_cfg_if.sv
// ----------------------------------------------------------------------------
// pclut_cfg_if
// Configuration write channel: register index and data with valid/ready.
// ----------------------------------------------------------------------------
interface pclut_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/palette_color_lookup_table.sv
// ----------------------------------------------------------------------------
// palette_color_lookup_table
// Multi-palette color lookup table with ARGB8888 expansion of loaded entries.
// ----------------------------------------------------------------------------
// Channels: req carries load beats (operation 0, raw_word) and read beats
// (operation 1, palette_index, entry_index); rsp returns one beat per read
// with the ARGB8888 color and in_range; cfg writes source_format (index 0),
// palette_count (1) and colors_per_palette (2). Any cfg beat to a known
// register rewinds the load position to palette 0, color 0.
// Loads are expanded and written to the table in the cycle they are
// accepted and give no response. A read passes through the table's
// registered read port and then the output register before it answers.
// Loads and reads alike are accepted one beat per cycle unless rsp stalls.
// When rsp stalls, one read waits in the output register and one more in
// the read stage; req.ready then drops until the output moves.
// Reset clears the registers (format 8888, one palette of one color, load
// position zero); table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module palette_color_lookup_table
	import pclut_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	pclut_req_if.sink  req,
	pclut_rsp_if.source rsp,
	pclut_cfg_if.sink  cfg
);

	pclut_ctrl_t       ctrl;
	logic              req_fire;
	logic              load_fire;
	logic              read_fire;
	logic              rd_ok;
	logic [ADDR_W-1:0] raddr;
	logic [31:0]       rdata;
	logic [31:0]       wdata;
	logic              valid_s1;
	logic              in_range_s1;
	logic              adv_s1;
	logic              out_valid_q;
	logic [31:0]       out_color_q;
	logic              out_in_range_q;

	assign adv_s1    = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv_s1;
	assign req_fire  = req.valid && req.ready;
	assign load_fire = req_fire && (req.operation == OP_LOAD);
	assign read_fire = req_fire && (req.operation == OP_READ);

	pclut_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.load_fire (load_fire),
		.ctrl      (ctrl)
	);

	assign wdata = expand(ctrl.fmt, req.raw_word);

	assign rd_ok = (req.palette_index < ctrl.pal_count) &&
		(req.palette_index < 8'(MAX_PALETTES)) &&
		(req.entry_index < ctrl.col_count) &&
		({1'b0, req.entry_index} < 9'(MAX_COLORS));
	assign raddr = {req.palette_index[PAL_W-1:0], req.entry_index[COL_W-1:0]};

	pclut_ram #(
		.ADDR_BITS (ADDR_W),
		.DATA_BITS (32)
	) u_ram (
		.clk   (clk),
		.we    (ctrl.we),
		.waddr (ctrl.waddr),
		.wdata (wdata),
		.re    (read_fire),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (read_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (read_fire) begin
			in_range_s1 <= rd_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// out-of-range reads answer zero
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_color_q    <= in_range_s1 ? rdata : 32'h0;
			out_in_range_q <= in_range_s1;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.color    = out_color_q;
	assign rsp.in_range = out_in_range_q;

	a_zero_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_in_range_q) |-> (out_color_q == 32'h0))
		else $error("out-of-range beat carries a color");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |=>
		(out_valid_q && $stable(out_color_q) && $stable(out_in_range_q)))
		else $error("response beat changed while stalled");

	a_req_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (valid_s1 && out_valid_q && !rsp.ready))
		else $error("request stalled with room in the pipeline");

endmodule

### rtl/pclut_ram.sv
// ----------------------------------------------------------------------------
// pclut_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pclut_ram #(
	parameter int ADDR_BITS = 12,
	parameter int DATA_BITS = 32
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [DATA_BITS-1:0] wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [DATA_BITS-1:0] rdata
);

	logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/pclut_cfg.sv
// ----------------------------------------------------------------------------
// pclut_cfg
// Configuration registers and the load position that walks the table.
// ----------------------------------------------------------------------------
module pclut_cfg
	import pclut_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	pclut_cfg_if.sink   cfg,
	input  logic        load_fire,
	output pclut_ctrl_t ctrl
);

	logic [1:0]      fmt_q;
	logic [7:0]      pal_count_q;
	logic [7:0]      col_count_q;
	logic [LP_W-1:0] lp_q;
	logic [7:0]      lc_q;
	logic            cfg_fire;
	logic            cfg_hit;
	logic            pos_ok;
	logic [8:0]      lc_inc;
	logic            lc_wrap;

	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign cfg_hit   = cfg_fire && (cfg.index == REG_FORMAT || cfg.index == REG_PAL_COUNT ||
		cfg.index == REG_COL_COUNT);

	assign pos_ok = ({{(8-LP_W){1'b0}}, lp_q} < pal_count_q) &&
		(lp_q < LP_W'(MAX_PALETTES)) &&
		(lc_q < col_count_q) && ({1'b0, lc_q} < 9'(MAX_COLORS));

	assign lc_inc  = {1'b0, lc_q} + 9'd1;
	assign lc_wrap = (lc_inc >= {1'b0, col_count_q}) || (lc_inc >= 9'(MAX_COLORS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q       <= FMT_8888;
			pal_count_q <= 8'd1;
			col_count_q <= 8'd1;
			lp_q        <= '0;
			lc_q        <= '0;
		end else if (cfg_hit) begin
			case (cfg.index)
				REG_FORMAT:    fmt_q       <= cfg.data[1:0];
				REG_PAL_COUNT: pal_count_q <= cfg.data;
				REG_COL_COUNT: col_count_q <= cfg.data;
				default:       fmt_q       <= fmt_q;
			endcase
			lp_q <= '0;
			lc_q <= '0;
		end else if (load_fire && pos_ok) begin
			if (lc_wrap) begin
				lc_q <= '0;
				lp_q <= lp_q + LP_W'(1);
			end else begin
				lc_q <= lc_inc[7:0];
			end
		end
	end

	assign ctrl.we        = load_fire && pos_ok;
	assign ctrl.waddr     = {lp_q[PAL_W-1:0], lc_q[COL_W-1:0]};
	assign ctrl.fmt       = fmt_q;
	assign ctrl.pal_count = pal_count_q;
	assign ctrl.col_count = col_count_q;

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lp_q <= LP_W'(MAX_PALETTES))
		else $error("load palette position past table");

	a_cfg_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> (lp_q == '0 && lc_q == '0))
		else $error("load position not rewound after config beat");

	a_we_in_size: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.we |-> (lc_q < col_count_q && {{(8-LP_W){1'b0}}, lp_q} < pal_count_q))
		else $error("table write outside configured size");

endmodule
